// File: rtl/websocket_frame_deframer_defines.svh
// Assertion macros shared by the queue and the parser modules.
// Each macro expects signals named clock and reset in the module that uses it.
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define WSDFR_ASSERT_SAME(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer check failed in the same cycle");

// The consequent holds in the cycle after the antecedent.
`define WSDFR_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer check failed one cycle later");

`endif

// File: rtl/wsdfr_pkg.sv
package wsdfr_pkg;

   // Parser phases.
   typedef enum logic [2:0] {
      PH_HDR0,
      PH_HDR1,
      PH_EXTLEN,
      PH_MASK,
      PH_DATA,
      PH_HALT
   } phase_type;

   // Result kinds.
   localparam logic [1:0] EV_DATA    = 2'd0;
   localparam logic [1:0] EV_EMPTY   = 2'd1;
   localparam logic [1:0] EV_TOOLONG = 2'd2;

   // Seven-bit length codes that announce an extended length.
   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [15:0] MAX_LEN_RESET = 16'd8192;

   localparam int unsigned QUEUE_DEPTH = 2;

   // One classified result on its way from the parser to the output stage.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [7:0] key;
      logic       last;
      logic       fin;
      logic [3:0] opcode;
   } cmd_type;

endpackage

// File: rtl/wsdfr_queue.sv
`include "websocket_frame_deframer_defines.svh"

module wsdfr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wsdfr_pkg::cmd_type push_cmd,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output wsdfr_pkg::cmd_type head_cmd
);
   import wsdfr_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QUEUE_DEPTH);
   localparam int unsigned CntWidth = $clog2(QUEUE_DEPTH + 1);

   cmd_type               entry_ff [QUEUE_DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;

   assign full       = (count_ff == CntWidth'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `WSDFR_ASSERT_SAME(a_no_overflow, push && full, pop)
   `WSDFR_ASSERT_SAME(a_no_underflow, pop, head_valid)
   `WSDFR_ASSERT_SAME(a_count_bound, 1'b1, count_ff <= CntWidth'(QUEUE_DEPTH))

endmodule

// File: rtl/wsdfr_front.sv
`include "websocket_frame_deframer_defines.svh"

module wsdfr_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   input  logic [15:0]        max_len,
   output logic               push,
   output wsdfr_pkg::cmd_type cmd
);
   import wsdfr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        mask_ff, mask_in;
   logic [2:0]  left_ff, left_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   // Set when a length byte pushed nonzero bits past bit 15.
   logic        over_ff, over_in;

   logic [6:0]  len7;
   logic [15:0] ext_len;
   logic        ext_over;
   logic [15:0] known_len;
   logic        known_over;
   logic        mask_now;
   logic        length_done;
   logic        too_long;
   logic        data_last;
   logic [7:0]  key_byte;
   phase_type   after_len_phase;

   assign len7     = rx_byte[6:0];
   assign ext_len  = {len_ff[7:0], rx_byte};
   assign ext_over = over_ff | (len_ff[15:8] != 8'd0);
   assign data_last = (len_ff == 16'd1);

   always_comb begin
      known_len   = ext_len;
      known_over  = ext_over;
      mask_now    = mask_ff;
      length_done = 1'b0;
      case (phase_ff)
         PH_HDR1: begin
            known_len   = {9'd0, len7};
            known_over  = 1'b0;
            mask_now    = rx_byte[7];
            length_done = (len7 != LEN_EXT16) && (len7 != LEN_EXT64);
         end
         PH_EXTLEN: begin
            length_done = (left_ff == 3'd0);
         end
         default: begin
         end
      endcase
   end

   assign too_long = known_over || (known_len > max_len);

   always_comb begin
      case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
   end

   always_comb begin
      if (too_long) begin
         after_len_phase = PH_HALT;
      end else if (mask_now) begin
         after_len_phase = PH_MASK;
      end else if (known_len == 16'd0) begin
         after_len_phase = PH_HDR0;
      end else begin
         after_len_phase = PH_DATA;
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         case (phase_ff)
            PH_HDR0: phase_in = PH_HDR1;
            PH_HDR1: phase_in = length_done ? after_len_phase : PH_EXTLEN;
            PH_EXTLEN: begin
               if (length_done) begin
                  phase_in = after_len_phase;
               end
            end
            PH_MASK: begin
               if (left_ff == 3'd0) begin
                  phase_in = (len_ff == 16'd0) ? PH_HDR0 : PH_DATA;
               end
            end
            PH_DATA: begin
               if (data_last) begin
                  phase_in = PH_HDR0;
               end
            end
            PH_HALT: phase_in = PH_HALT;
            default: phase_in = PH_HDR0;
         endcase
      end
   end

   // Results handed to the queue.
   always_comb begin
      push       = 1'b0;
      cmd.kind   = EV_DATA;
      cmd.data   = 8'd0;
      cmd.key    = 8'd0;
      cmd.last   = 1'b0;
      cmd.fin    = 1'b0;
      cmd.opcode = opcode_ff;
      if (accept) begin
         case (phase_ff)
            PH_HDR1, PH_EXTLEN: begin
               if (length_done && too_long) begin
                  push     = 1'b1;
                  cmd.kind = EV_TOOLONG;
               end else if (length_done && !mask_now && known_len == 16'd0) begin
                  push     = 1'b1;
                  cmd.kind = EV_EMPTY;
                  cmd.last = 1'b1;
                  cmd.fin  = fin_ff;
               end
            end
            PH_MASK: begin
               if (left_ff == 3'd0 && len_ff == 16'd0) begin
                  push     = 1'b1;
                  cmd.kind = EV_EMPTY;
                  cmd.last = 1'b1;
                  cmd.fin  = fin_ff;
               end
            end
            PH_DATA: begin
               push     = 1'b1;
               cmd.data = rx_byte;
               cmd.key  = key_byte;
               cmd.last = data_last;
               cmd.fin  = data_last & fin_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Header fields, length and mask key.
   always_comb begin
      fin_in    = fin_ff;
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      left_in   = left_ff;
      key_in    = key_ff;
      pos_in    = pos_ff;
      len_in    = len_ff;
      over_in   = over_ff;
      if (accept) begin
         case (phase_ff)
            PH_HDR0: begin
               fin_in    = rx_byte[7];
               opcode_in = rx_byte[3:0];
            end
            PH_HDR1: begin
               mask_in = rx_byte[7];
               // An extended length is built up from zero by the bytes that follow.
               len_in  = length_done ? {9'd0, len7} : 16'd0;
               over_in = 1'b0;
               if (length_done) begin
                  left_in = 3'd3;
                  key_in  = 32'd0;
                  pos_in  = 2'd0;
               end else begin
                  left_in = (len7 == LEN_EXT64) ? 3'd7 : 3'd1;
               end
            end
            PH_EXTLEN: begin
               len_in  = ext_len;
               over_in = ext_over;
               if (length_done) begin
                  left_in = 3'd3;
                  key_in  = 32'd0;
                  pos_in  = 2'd0;
               end else begin
                  left_in = left_ff - 3'd1;
               end
            end
            PH_MASK: begin
               key_in = {key_ff[23:0], rx_byte};
               pos_in = 2'd0;
               if (left_ff != 3'd0) begin
                  left_in = left_ff - 3'd1;
               end
            end
            PH_DATA: begin
               pos_in = pos_ff + 2'd1;
               len_in = len_ff - 16'd1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HDR0;
         fin_ff    <= 1'b0;
         opcode_ff <= 4'd0;
         mask_ff   <= 1'b0;
         left_ff   <= 3'd0;
         key_ff    <= 32'd0;
         pos_ff    <= 2'd0;
         len_ff    <= 16'd0;
         over_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         fin_ff    <= fin_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         left_ff   <= left_in;
         key_ff    <= key_in;
         pos_ff    <= pos_in;
         len_ff    <= len_in;
         over_ff   <= over_in;
      end
   end

   `WSDFR_ASSERT_NEXT(a_halt_sticks, phase_ff == PH_HALT, phase_ff == PH_HALT)
   `WSDFR_ASSERT_NEXT(a_toolong_halts, push && cmd.kind == EV_TOOLONG, phase_ff == PH_HALT)
   `WSDFR_ASSERT_SAME(a_data_has_bytes, phase_ff == PH_DATA, len_ff != 16'd0)

endmodule

// File: rtl/wsdfr_back.sv
module wsdfr_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  wsdfr_pkg::cmd_type head_cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_event_kind,
   output logic [7:0]         rsp_payload_byte,
   output logic               rsp_frame_last,
   output logic               rsp_final_fragment,
   output logic [3:0]         rsp_frame_opcode
);
   import wsdfr_pkg::*;

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       fin_ff;
   logic [3:0] opcode_ff;

   // Load a new result whenever the output register is free or being taken.
   assign pop = head_valid && (!valid_ff || !rsp_stall);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff   <= head_cmd.kind;
         byte_ff   <= head_cmd.data ^ head_cmd.key;
         last_ff   <= head_cmd.last;
         fin_ff    <= head_cmd.fin;
         opcode_ff <= head_cmd.opcode;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_event_kind     = kind_ff;
   assign rsp_payload_byte   = byte_ff;
   assign rsp_frame_last     = last_ff;
   assign rsp_final_fragment = fin_ff;
   assign rsp_frame_opcode   = opcode_ff;

endmodule

// File: rtl/websocket_frame_deframer.sv
// Channel    Direction  Handshake         Payload
// req_       in         valid / stall     rx_byte (8)
// rsp_       out        valid / stall     event_kind, payload_byte, frame_last,
//                                         final_fragment, frame_opcode
// csr_       in         valid / ready     max_frame_length (16)
//
// One stream byte is taken every clock cycle while req_stall is low; a result
// passes through the two-entry queue and then the output register on its way to
// rsp_. req_stall rises only while that queue holds two results, which happens
// when rsp_stall has held the output register for a while.
// Reset is synchronous and active high; it returns max_frame_length to 8192 and
// is the only way out of the halt that follows a frame that is too long.
module websocket_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   // Byte stream from the client.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   // Parsed results.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_frame_last,
   output logic        rsp_final_fragment,
   output logic [3:0]  rsp_frame_opcode,
   // Length limit register.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_max_frame_length
);
   import wsdfr_pkg::*;

   // The limit register accepts a write in any cycle. The user must write it only while
   // no request is in flight, so the parser never sees it change mid-frame; the block does not enforce it.
   logic [15:0] max_len_ff, max_len_in;

   logic        queue_full;
   logic        req_accept;
   logic        front_push;
   cmd_type     front_cmd;
   logic        head_valid;
   cmd_type     head_cmd;
   logic        back_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      max_len_in = max_len_ff;
      if (csr_valid && csr_ready) begin
         max_len_in = csr_max_frame_length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   // A request is held off only when the queue cannot take another result, so
   // the parser may push on every accepted request without further checks.
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // The parser walks the header, builds the length and mask key, and turns each
   // accepted request into at most one classified result.
   wsdfr_front u_front (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .max_len (max_len_ff),
      .push    (front_push),
      .cmd     (front_cmd)
   );

   // The queue decouples the parser from the output stage so that a stall on the
   // result side does not stop the byte stream at once.
   wsdfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (front_push),
      .push_cmd   (front_cmd),
      .pop        (back_pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // The output stage removes the mask and holds each result until it is taken.
   wsdfr_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .pop                (back_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_event_kind     (rsp_event_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_last     (rsp_frame_last),
      .rsp_final_fragment (rsp_final_fragment),
      .rsp_frame_opcode   (rsp_frame_opcode)
   );

endmodule

// File: test/tb.sv
module tb;
   import wsdfr_pkg::*;

   // Opcode nibbles that the directed frames use by name.
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;

   // A result passes through the queue and the output register of the block; the drain
   // lets any header byte still in flight settle before a register write.
   localparam int DRAIN_CYCLES = 8;
   localparam int HOLD_CYCLES  = 300;

   // The three ways a frame header can carry its payload length.
   typedef enum int {
      FORM_SHORT,
      FORM_EXT16,
      FORM_EXT64
   } length_form_type;

   // One result as it appears on the rsp_ channel.
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic       last;
      logic       fin;
      logic [3:0] opcode;
   } frame_result_type;

   // The scoreboard keeps its own copy of the parser state and of the length
   // limit. Every accepted stream byte advances that state, and any result the
   // byte causes is queued here until the block delivers it.
   class deframer_scoreboard;
      logic [15:0]      limit;
      phase_type        phase;
      logic             frame_fin;
      logic [3:0]       frame_opcode;
      logic             masked;
      logic [2:0]       hdr_left;
      logic [31:0]      key;
      logic [1:0]       key_index;
      logic [63:0]      bytes_left;
      frame_result_type pending_events[$];
      int               mismatches;

      function void clear();
         limit        = MAX_LEN_RESET;
         phase        = PH_HDR0;
         frame_fin    = 1'b0;
         frame_opcode = 4'h0;
         masked       = 1'b0;
         hdr_left     = 3'd0;
         key          = 32'h0;
         key_index    = 2'd0;
         bytes_left   = 64'h0;
         pending_events.delete();
         mismatches   = 0;
      endfunction

      function void set_limit(logic [15:0] value);
         limit = value;
      endfunction

      function void emit(logic [1:0] kind, logic [7:0] data, logic last);
         frame_result_type r;
         r.kind   = kind;
         r.data   = data;
         r.last   = last;
         r.fin    = last ? frame_fin : 1'b0;
         r.opcode = frame_opcode;
         pending_events = {pending_events, r};
      endfunction

      // Reached after the last mask byte, or right after the length when the
      // frame is not masked. An empty frame completes here.
      function void start_payload();
         key_index = 2'd0;
         if (bytes_left == 64'h0) begin
            phase = PH_HDR0;
            emit(EV_EMPTY, 8'h00, 1'b1);
         end else begin
            phase = PH_DATA;
         end
      endfunction

      // The limit applies to all three length forms. A frame over the limit
      // halts the parser for good.
      function void length_done();
         if (bytes_left > {48'h0, limit}) begin
            phase = PH_HALT;
            emit(EV_TOOLONG, 8'h00, 1'b0);
         end else if (masked) begin
            phase    = PH_MASK;
            hdr_left = 3'd3;
            key      = 32'h0;
         end else begin
            key = 32'h0;
            start_payload();
         end
      endfunction

      function void parse_byte(logic [7:0] rx);
         logic [7:0] key_byte;
         case (phase)
            PH_HDR0: begin
               frame_fin    = rx[7];
               frame_opcode = rx[3:0];
               phase        = PH_HDR1;
            end
            PH_HDR1: begin
               masked     = rx[7];
               bytes_left = 64'h0;
               if (rx[6:0] == LEN_EXT64) begin
                  hdr_left = 3'd7;
                  phase    = PH_EXTLEN;
               end else if (rx[6:0] == LEN_EXT16) begin
                  hdr_left = 3'd1;
                  phase    = PH_EXTLEN;
               end else begin
                  bytes_left = {57'h0, rx[6:0]};
                  length_done();
               end
            end
            PH_EXTLEN: begin
               bytes_left = {bytes_left[55:0], rx};
               if (hdr_left == 3'd0) length_done();
               else hdr_left = hdr_left - 3'd1;
            end
            PH_MASK: begin
               key = {key[23:0], rx};
               if (hdr_left == 3'd0) start_payload();
               else hdr_left = hdr_left - 3'd1;
            end
            PH_DATA: begin
               // Key bytes are applied in wire order, the first one received first.
               key_byte   = key[8 * (3 - int'(key_index)) +: 8];
               key_index  = key_index + 2'd1;
               bytes_left = bytes_left - 64'h1;
               if (bytes_left == 64'h0) begin
                  phase = PH_HDR0;
                  emit(EV_DATA, rx ^ key_byte, 1'b1);
               end else begin
                  emit(EV_DATA, rx ^ key_byte, 1'b0);
               end
            end
            default: begin
            end
         endcase
      endfunction

      function string describe(frame_result_type r);
         return $sformatf("kind %0d data %02h last %0d fin %0d opcode %0d",
                          r.kind, r.data, r.last, r.fin, r.opcode);
      endfunction

      function void check_event(frame_result_type got);
         frame_result_type want;
         if (pending_events.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: %s", describe(got));
            return;
         end
         want = pending_events.pop_front();
         if (got.kind !== want.kind || got.data !== want.data || got.last !== want.last ||
             got.fin !== want.fin || got.opcode !== want.opcode) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected %s, actual %s",
                        describe(want), describe(got));
         end
      endfunction
   endclass

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_event_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_frame_last;
   logic        rsp_final_fragment;
   logic [3:0]  rsp_frame_opcode;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_max_frame_length;

   deframer_scoreboard sb;

   // Percentages of cycles in which the sender idles and the receiver stalls.
   // The main sequence changes them from phase to phase.
   int idle_pct  = 0;
   int stall_pct = 0;
   // Set by the main sequence to ask the receiver for one long hold-off.
   bit hold_ask  = 1'b0;
   int bytes_sent = 0;

   websocket_frame_deframer dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_rx_byte          (req_rx_byte),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_event_kind       (rsp_event_kind),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_frame_last       (rsp_frame_last),
      .rsp_final_fragment   (rsp_final_fragment),
      .rsp_frame_opcode     (rsp_frame_opcode),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_max_frame_length (csr_max_frame_length)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // The receiver stalls at random at the rate the current phase asks for.
   // When a long hold-off is requested it keeps rsp_stall high for a counted
   // stretch, long enough for the block to fill its queue and stall its input.
   initial begin : receiver
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_ask) begin
            hold_ask  = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Every result is taken at the edge where rsp_valid is high and rsp_stall
   // is low, and is compared with the oldest expectation.
   always @(posedge clock) begin
      frame_result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind   = rsp_event_kind;
         got.data   = rsp_payload_byte;
         got.last   = rsp_frame_last;
         got.fin    = rsp_final_fragment;
         got.opcode = rsp_frame_opcode;
         sb.check_event(got);
      end
   end

   // Offers one stream byte and waits until the block takes the request. A
   // held request keeps its byte; idle cycles come before the offer only.
   task automatic send_byte(input logic [7:0] value);
      while ((idle_pct > 0) && ($urandom_range(99) < idle_pct)) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.parse_byte(value);
      bytes_sent++;
   endtask

   // Sends one whole frame: both header bytes, the length extension, the
   // mask key and the payload. The reserved bits of the first byte are random.
   // A frame over the current limit stops after its length, since the block
   // halts there.
   task automatic send_frame(input logic fin_bit, input logic [3:0] opcode,
                             input logic masked, input logic [63:0] length,
                             input length_form_type form);
      logic [31:0] key;
      key = $urandom;
      send_byte({fin_bit, 3'($urandom), opcode});
      case (form)
         FORM_SHORT: begin
            send_byte({masked, length[6:0]});
         end
         FORM_EXT16: begin
            send_byte({masked, LEN_EXT16});
            send_byte(length[15:8]);
            send_byte(length[7:0]);
         end
         default: begin
            send_byte({masked, LEN_EXT64});
            for (int i = 7; i >= 0; i--) send_byte(length[8 * i +: 8]);
         end
      endcase
      if (length > {48'h0, sb.limit}) return;
      if (masked)
         for (int i = 3; i >= 0; i--) send_byte(key[8 * i +: 8]);
      for (int n = 0; n < int'(length); n++) send_byte(8'($urandom));
   endtask

   // Random frames within the current limit. Most are short; some sit right at the
   // lower of the limit and cap, and short lengths sometimes use a longer encoding than needed.
   task automatic send_frames(input int budget, input int cap);
      int              start;
      int              top;
      int              pick;
      logic [63:0]     length;
      length_form_type form;
      start = bytes_sent;
      while (bytes_sent - start < budget) begin
         top  = (int'(sb.limit) < cap) ? int'(sb.limit) : cap;
         pick = $urandom_range(99);
         if (pick < 8) length = 64'(top);
         else if (pick < 20) length = 64'($urandom_range(top, 0));
         else length = 64'($urandom_range((top < 12) ? top : 12, 0));
         pick = $urandom_range(99);
         if (length >= 64'd126) form = (pick < 50) ? FORM_EXT16 : FORM_EXT64;
         else if (pick < 80) form = FORM_SHORT;
         else if (pick < 90) form = FORM_EXT16;
         else form = FORM_EXT64;
         send_frame(1'($urandom_range(1)), 4'($urandom), 1'($urandom_range(1)), length, form);
      end
   endtask

   // The sender stops and waits until every expected result has come, then
   // gives any header bytes still inside the block time to settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_valid            <= 1'b1;
      csr_max_frame_length <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.set_limit(value);
   endtask

   initial begin
      sb = new;
      sb.clear();
      req_valid            <= 1'b0;
      req_rx_byte          <= 8'h00;
      csr_valid            <= 1'b0;
      csr_max_frame_length <= 16'h0000;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames at the reset limit, with no idling on either side:
      // an empty unmasked frame, an empty masked frame that completes on its
      // fourth key byte, a short masked payload, a one-byte payload with its
      // length in the 16-bit form, and an empty frame in the 64-bit form.
      send_frame(1'b1, OP_TEXT,   1'b0, 64'd0, FORM_SHORT);
      send_frame(1'b1, OP_PING,   1'b1, 64'd0, FORM_SHORT);
      send_frame(1'b0, OP_BINARY, 1'b1, 64'd2, FORM_SHORT);
      send_frame(1'b1, OP_CONT,   1'b0, 64'd1, FORM_EXT16);
      send_frame(1'b1, OP_CLOSE,  1'b0, 64'd0, FORM_EXT64);
      wait_drained();

      // Limit at zero: only empty frames pass. The sender idles heavily.
      write_limit(16'h0000);
      idle_pct = 79;
      send_frames(150, 0);
      wait_drained();

      // Largest limit, with the receiver stalling heavily. Payloads up to a
      // few hundred bytes bring in the extended length forms.
      write_limit(16'hffff);
      idle_pct  = 0;
      stall_pct = 79;
      send_frames(350, 300);
      wait_drained();

      // A small limit, so frames often land exactly on it, with light idling
      // on both sides.
      write_limit(16'($urandom_range(40, 1)));
      idle_pct  = 10;
      stall_pct = 10;
      send_frames(350, 300);
      wait_drained();

      // Back-pressure: the receiver holds off for a long stretch while the
      // sender keeps offering at full rate, so the block has to stall requests.
      write_limit(16'd200);
      idle_pct  = 0;
      stall_pct = 0;
      hold_ask  = 1'b1;
      send_frames(200, 200);
      wait_drained();
      stall_pct = 10;
      send_frames(100, 200);
      wait_drained();

      // A frame over the limit halts the block until reset, so it can only
      // come last. The bytes after it must be taken and dropped.
      if ($urandom_range(1) == 0)
         send_frame(1'b1, OP_BINARY, 1'($urandom_range(1)),
                    64'($urandom_range(65535, 201)), FORM_EXT16);
      else
         send_frame(1'b0, OP_TEXT, 1'($urandom_range(1)),
                    {32'($urandom) | 32'h1, 32'($urandom)}, FORM_EXT64);
      repeat (4) send_byte(8'($urandom));
      wait_drained();

      if (sb.mismatches == 0 && sb.pending_events.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // The slowest correct run takes well under a tenth of this.
   initial begin
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/wsdfr_pkg.sv
rtl/wsdfr_queue.sv
rtl/wsdfr_front.sv
rtl/wsdfr_back.sv
rtl/websocket_frame_deframer.sv
test/tb.sv
